// ===== sv/ftu_pkg.sv =====
// Shared types and constants for the texel format unpacker.
// Used by ftu_front, ftu_fifo, ftu_back and texel_format_unpacker; no dependencies.
package ftu_pkg;

  // Largest image side the position counters are sized for.
  localparam int unsigned MaxSideDefault = 1024;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Job queue between front and back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = 1;
  localparam int unsigned FifoLvlW  = 2;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_MODE    = 2'd0,
    CFG_IMAGE_WIDTH   = 2'd1,
    CFG_IMAGE_HEIGHT  = 2'd2,
    CFG_ROW_ALIGNMENT = 2'd3
  } cfg_index_e;

  // Source texel formats.
  typedef enum logic [2:0] {
    MODE_RGBA8    = 3'd0,
    MODE_BGRA8    = 3'd1,
    MODE_RGBA5551 = 3'd2,
    MODE_BGRA5551 = 3'd3,
    MODE_A8       = 3'd4
  } pixel_mode_e;

  // Configuration register contents as seen by the front end.
  typedef struct packed {
    logic [2:0]  mode;
    logic [10:0] width;
    logic [10:0] height;
    logic [3:0]  align;
  } cfg_regs_t;

  // One assembled texel waiting for format conversion.
  typedef struct packed {
    pixel_mode_e mode;
    logic [31:0] word;
    logic [19:0] index;
    logic        last;
  } texel_job_t;

  // Queue occupancy reported to the top level.
  typedef struct packed {
    logic                full;
    logic                empty;
    logic [FifoLvlW-1:0] level;
  } fifo_status_t;

endpackage

// ===== sv/ftu_front.sv =====
// Front end of the texel unpacker: byte intake, padding skip, texel assembly
// and position tracking. Depends on ftu_pkg.
module ftu_front #(
  parameter int unsigned MaxSide = ftu_pkg::MaxSideDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ftu_pkg::cfg_regs_t    cfg_i,
  input  logic                  clear_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            source_byte_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output ftu_pkg::texel_job_t   push_job_o
);

  localparam int unsigned SideW = $clog2(MaxSide + 1);

  logic [SideW-1:0] col_q, col_d;
  logic [SideW-1:0] row_q, row_d;
  logic [1:0]       phase_q, phase_d;
  logic [23:0]      held_q, held_d;
  logic [2:0]       rbo_q, rbo_d;
  logic [2:0]       pad_q, pad_d;
  logic [19:0]      base_q, base_d;

  logic [SideW-1:0] side_w, side_h;
  logic             active;
  logic [1:0]       last_phase;
  logic             completes;
  logic             accept;
  logic [2:0]       rbo_inc;
  logic [2:0]       align_mask;
  logic [SideW:0]   col_inc, row_inc;
  logic             row_end, img_end;
  logic [31:0]      word;

  // Clamp the sides to the counter range.
  always_comb begin
    if (32'(cfg_i.width) > MaxSide) side_w = SideW'(MaxSide);
    else side_w = SideW'(cfg_i.width);
    if (32'(cfg_i.height) > MaxSide) side_h = SideW'(MaxSide);
    else side_h = SideW'(cfg_i.height);
  end

  // Bytes per texel, expressed as the phase of the final byte.
  always_comb begin
    unique case (cfg_i.mode)
      ftu_pkg::MODE_RGBA8, ftu_pkg::MODE_BGRA8:       last_phase = 2'd3;
      ftu_pkg::MODE_RGBA5551, ftu_pkg::MODE_BGRA5551: last_phase = 2'd1;
      default:                                        last_phase = 2'd0;
    endcase
  end

  assign active    = (side_w != '0) && (side_h != '0) && (cfg_i.mode <= ftu_pkg::MODE_A8);
  assign completes = active && (pad_q == 3'd0) && (phase_q == last_phase);
  // A byte that finishes a texel needs room in the queue; others always go in.
  assign in_ready_o   = !completes || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = accept && completes;

  // Place the final byte above the held ones.
  always_comb begin
    unique case (last_phase)
      2'd3:    word = {source_byte_i, held_q};
      2'd1:    word = {16'd0, source_byte_i, held_q[7:0]};
      default: word = {24'd0, source_byte_i};
    endcase
  end

  assign rbo_inc = rbo_q + 3'd1;
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign row_end = col_inc >= {1'b0, side_w};
  assign img_end = row_inc >= {1'b0, side_h};

  // Alignments other than 2, 4 and 8 add no padding.
  always_comb begin
    unique case (cfg_i.align)
      4'd2:    align_mask = 3'd1;
      4'd4:    align_mask = 3'd3;
      4'd8:    align_mask = 3'd7;
      default: align_mask = 3'd0;
    endcase
  end

  assign push_job_o.mode  = ftu_pkg::pixel_mode_e'(cfg_i.mode);
  assign push_job_o.word  = word;
  assign push_job_o.index = base_q + 20'(col_q);
  assign push_job_o.last  = row_end && img_end;

  // Position and assembly state update.
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    held_d  = held_q;
    rbo_d   = rbo_q;
    pad_d   = pad_q;
    base_d  = base_q;
    if (clear_i) begin
      col_d   = '0;
      row_d   = '0;
      phase_d = '0;
      held_d  = '0;
      rbo_d   = '0;
      pad_d   = '0;
      base_d  = '0;
    end else if (accept && active) begin
      if (pad_q != 3'd0) begin
        pad_d = pad_q - 3'd1;
      end else if (!completes) begin
        rbo_d   = rbo_inc;
        held_d  = held_q | (24'(source_byte_i) << {phase_q, 3'b000});
        phase_d = phase_q + 2'd1;
      end else begin
        rbo_d   = rbo_inc;
        phase_d = '0;
        held_d  = '0;
        col_d   = col_inc[SideW-1:0];
        if (row_end) begin
          col_d = '0;
          rbo_d = '0;
          pad_d = (3'd0 - rbo_inc) & align_mask;
          if (img_end) begin
            row_d  = '0;
            base_d = '0;
          end else begin
            row_d  = row_inc[SideW-1:0];
            base_d = base_q + 20'(side_w);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      held_q  <= '0;
      rbo_q   <= '0;
      pad_q   <= '0;
      base_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
      held_q  <= held_d;
      rbo_q   <= rbo_d;
      pad_q   <= pad_d;
      base_q  <= base_d;
    end
  end

endmodule

// ===== sv/ftu_fifo.sv =====
// Two-entry job queue that decouples the unpacker front end from the back end.
// Depends on ftu_pkg.
module ftu_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  ftu_pkg::texel_job_t    push_job_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output ftu_pkg::texel_job_t    pop_job_o,
  output ftu_pkg::fifo_status_t  status_o
);

  ftu_pkg::texel_job_t mem_q [ftu_pkg::FifoDepth];

  logic [ftu_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ftu_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ftu_pkg::FifoLvlW-1:0] level_q, level_d;
  logic                         do_push, do_pop;

  assign push_ready_o = level_q != ftu_pkg::FifoLvlW'(ftu_pkg::FifoDepth);
  assign pop_valid_o  = level_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  assign status_o.full  = !push_ready_o;
  assign status_o.empty = !pop_valid_o;
  assign status_o.level = level_q;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_push && !do_pop) level_d = level_q + 1'b1;
    else if (do_pop && !do_push) level_d = level_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== sv/ftu_back.sv =====
// Back end of the texel unpacker: format conversion and the result register.
// Depends on ftu_pkg.
module ftu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  ftu_pkg::texel_job_t  pop_job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [19:0]          texel_index_o,
  output logic [7:0]           out_red_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_blue_o,
  output logic [7:0]           out_alpha_o,
  output logic                 last_texel_o
);

  // floor(v * 255 / 31) for every 5-bit channel value.
  localparam logic [7:0] Widen5Lut [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  logic        valid_q, valid_d;
  logic [19:0] index_q;
  logic [7:0]  px0_q, px1_q, px2_q, px3_q;
  logic        last_q;

  logic [7:0]  px0, px1, px2, px3;
  logic [7:0]  r5, g5, b5, a1;
  logic [31:0] t;
  logic        load;

  assign t  = pop_job_i.word;
  assign r5 = Widen5Lut[t[15:11]];
  assign g5 = Widen5Lut[t[10:6]];
  assign b5 = Widen5Lut[t[5:1]];
  assign a1 = {8{t[0]}};

  // Map the assembled word to the four texel bytes.
  always_comb begin
    unique case (pop_job_i.mode)
      ftu_pkg::MODE_RGBA8: begin
        px0 = t[7:0];   px1 = t[15:8];  px2 = t[23:16]; px3 = t[31:24];
      end
      ftu_pkg::MODE_BGRA8: begin
        px0 = t[31:24]; px1 = t[23:16]; px2 = t[15:8];  px3 = t[7:0];
      end
      ftu_pkg::MODE_RGBA5551: begin
        px0 = r5; px1 = g5; px2 = b5; px3 = a1;
      end
      ftu_pkg::MODE_BGRA5551: begin
        px0 = a1; px1 = b5; px2 = g5; px3 = r5;
      end
      default: begin
        px0 = 8'd0; px1 = 8'd0; px2 = 8'd0; px3 = t[7:0];
      end
    endcase
  end

  // The result register refills whenever it is empty or being drained.
  assign pop_ready_o = !valid_q || out_ready_i;
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      index_q <= pop_job_i.index;
      px0_q   <= px0;
      px1_q   <= px1;
      px2_q   <= px2;
      px3_q   <= px3;
      last_q  <= pop_job_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign texel_index_o = index_q;
  assign out_red_o     = px0_q;
  assign out_green_o   = px1_q;
  assign out_blue_o    = px2_q;
  assign out_alpha_o   = px3_q;
  assign last_texel_o  = last_q;

endmodule

// ===== sv/texel_format_unpacker.sv =====
// Top level of the texel format unpacker: configuration registers, front end,
// job queue and back end. Depends on ftu_pkg, ftu_front, ftu_fifo and ftu_back.
//
//   Channel   Direction  Handshake                Payload
//   cfg       in         cfg_we_i                 cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o  source_byte_i
//   out       out        out_valid_o / out_ready_i texel_index_o, out_*_o, last_texel_o
//
// One source byte is taken per cycle while the input does not stall; a texel takes four, two or one
// bytes by mode, plus any row padding; a texel leaves at most once per cycle.
// A texel's result passes through the queue entry, written when its final byte is accepted,
// and then the result register, which loads once that register is empty or being drained.
// Reset loads mode RGBA8, zero sides and alignment 4; a register write restarts the image.
// The input stalls only on a byte that completes a texel while the queue is full.
module texel_format_unpacker #(
  parameter int unsigned MaxSide = ftu_pkg::MaxSideDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ftu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ftu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   source_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [19:0]                  texel_index_o,
  output logic [7:0]                   out_red_o,
  output logic [7:0]                   out_green_o,
  output logic [7:0]                   out_blue_o,
  output logic [7:0]                   out_alpha_o,
  output logic                         last_texel_o
);

  ftu_pkg::cfg_regs_t    cfg_q, cfg_d;
  ftu_pkg::texel_job_t   push_job, pop_job;
  ftu_pkg::fifo_status_t fifo_status;
  logic                  push_valid, push_ready;
  logic                  pop_valid, pop_ready;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ftu_pkg::cfg_index_e'(cfg_index_i))
        ftu_pkg::CFG_PIXEL_MODE:    cfg_d.mode   = cfg_data_i[2:0];
        ftu_pkg::CFG_IMAGE_WIDTH:   cfg_d.width  = cfg_data_i[10:0];
        ftu_pkg::CFG_IMAGE_HEIGHT:  cfg_d.height = cfg_data_i[10:0];
        default:                    cfg_d.align  = cfg_data_i[3:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ftu_pkg::MODE_RGBA8;
      cfg_q.width  <= '0;
      cfg_q.height <= '0;
      cfg_q.align  <= 4'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ftu_front #(
    .MaxSide(MaxSide)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clear_i      (cfg_we_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .source_byte_i(source_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ftu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job),
    .status_o    (fifo_status)
  );

  ftu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_job_i    (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .texel_index_o(texel_index_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .last_texel_o (last_texel_o)
  );

`ifndef SYNTHESIS
  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> !fifo_status.full)
    else $error("job pushed into a full queue");

  // The queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.level <= ftu_pkg::FifoLvlW'(ftu_pkg::FifoDepth))
    else $error("queue level out of range");

  // With an empty image configured, bytes are always taken and dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.width == '0 || cfg_q.height == '0) |-> (in_ready_o && !push_valid))
    else $error("empty image stalled input or produced a texel");

  // An empty queue with nothing pushed leaves the result register unloaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_status.empty && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared without a queued job");
`endif

endmodule
